@@ rtl/allocation_leak_tracker_defines.svh @@
// Assertion macros shared by the leak tracker RTL.
`ifndef ALLOCATION_LEAK_TRACKER_DEFINES_SVH
`define ALLOCATION_LEAK_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside of reset.
`define ALT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("%m: check failed");
// Check a property on every clock edge, reset included.
`define ALT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
   else $error("%m: check failed");
`else
`define ALT_ASSERT(lbl, clk, rst, prop)
`define ALT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/alt_pkg.sv @@
// Types and constants shared by the leak tracker modules.
package alt_pkg;

   // Action codes of a request.
   localparam logic [1:0] ACT_ALLOC  = 2'd0;
   localparam logic [1:0] ACT_FREE   = 2'd1;
   localparam logic [1:0] ACT_REPORT = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_LEAK  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   // Largest number of records one report emits.
   localparam logic [6:0] REPORT_CAP = 7'd64;

   // Operation decided by the front end.
   typedef enum logic [2:0] {
      OP_ALLOC  = 3'd0,
      OP_FREE   = 3'd1,
      OP_REPORT = 3'd2,
      OP_ACK    = 3'd3,
      OP_EMPTY  = 3'd4
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] address;
      logic [31:0] alloc_size;
      logic [31:0] site_tag;
      logic [19:0] line_number;
      logic [6:0]  limit;
   } alt_cmd_type;

   typedef struct packed {
      logic enabled;
      logic clearing;
   } alt_status_type;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] size;
      logic [31:0] site;
      logic [19:0] line;
      logic [63:0] stamp;
   } alt_rec_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [31:0] size;
      logic [31:0] site;
      logic [19:0] line;
      logic [63:0] age;
      logic        matched;
   } alt_res_type;

   // A result that carries no record.
   function automatic alt_res_type plain_result(input logic [1:0] kind, input logic matched);
      alt_res_type r;
      r         = '0;
      r.kind    = kind;
      r.matched = matched;
      return r;
   endfunction

endpackage

@@ rtl/alt_ifs.sv @@
// Request and response channel interfaces.
interface alt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] address;
   logic [31:0] alloc_size;
   logic [31:0] site_tag;
   logic [19:0] line_number;
   logic [6:0]  report_limit;

   modport source (output valid, action, address, alloc_size, site_tag, line_number,
                   report_limit, input ready);
   modport sink (input valid, action, address, alloc_size, site_tag, line_number,
                 report_limit, output ready);
endinterface

interface alt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] leak_address;
   logic [31:0] leak_size;
   logic [31:0] leak_site;
   logic [19:0] leak_line;
   logic [63:0] leak_age;
   logic        free_matched;
   logic        last;
   logic [63:0] alloc_count;
   logic [63:0] free_count;
   logic [63:0] bytes_allocated;
   logic [63:0] bytes_freed;

   modport source (output valid, result_kind, leak_address, leak_size, leak_site, leak_line,
                   leak_age, free_matched, last, alloc_count, free_count,
                   bytes_allocated, bytes_freed, input ready);
   modport sink (input valid, result_kind, leak_address, leak_size, leak_site, leak_line,
                 leak_age, free_matched, last, alloc_count, free_count,
                 bytes_allocated, bytes_freed, output ready);
endinterface

@@ rtl/alt_ram.sv @@
// Generic single write port RAM with a registered read port.
module alt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

@@ rtl/alt_front.sv @@
// Front end: accepts requests, classifies them and queues commands.
`include "allocation_leak_tracker_defines.svh"
module alt_front import alt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   alt_req_if.sink        req_chan,
   input  alt_status_type status,
   output logic           cmd_valid,
   output alt_cmd_type    cmd,
   input  logic           cmd_pop
);
   alt_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   alt_cmd_type new_cmd;
   logic        accept;
   logic [6:0]  limit;

   assign req_chan.ready = (count_ff != 2'd2) && !status.clearing;
   assign accept         = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (count_ff != 2'd0);
   assign cmd            = entry_ff[rd_ptr_ff];

   // Classify the incoming transaction.
   always_comb begin
      limit                 = (req_chan.report_limit > REPORT_CAP) ? REPORT_CAP
                                                                   : req_chan.report_limit;
      new_cmd.address     = req_chan.address;
      new_cmd.alloc_size  = req_chan.alloc_size;
      new_cmd.site_tag    = req_chan.site_tag;
      new_cmd.line_number = req_chan.line_number;
      new_cmd.limit       = limit;
      case (req_chan.action)
         ACT_ALLOC: begin
            new_cmd.op = status.enabled ? OP_ALLOC : OP_ACK;
         end
         ACT_FREE: begin
            new_cmd.op = status.enabled ? OP_FREE : OP_ACK;
         end
         ACT_REPORT: begin
            new_cmd.op = (status.enabled && limit != 7'd0) ? OP_REPORT : OP_EMPTY;
         end
         default: begin
            new_cmd.op = OP_ACK;
         end
      endcase
   end

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(accept) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   `ALT_ASSERT_ALWAYS(a_reset_empties_queue, clock, reset |=> (count_ff == 2'd0))
   `ALT_ASSERT(a_full_queue_holds, clock, reset,
               (count_ff == 2'd2 && !cmd_pop) |=> (count_ff == 2'd2))
   `ALT_ASSERT(a_pop_needs_command, clock, reset, cmd_pop |-> cmd_valid)
endmodule

@@ rtl/alt_back.sv @@
// Back end: executes commands against the record table and drives results.
`include "allocation_leak_tracker_defines.svh"
module alt_back import alt_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  logic           csr_write_data,
   input  logic           cmd_valid,
   input  alt_cmd_type    cmd,
   output logic           cmd_pop,
   output alt_status_type status,
   alt_rsp_if.source      rsp_chan
);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic        enabled_ff, enabled_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0] ring_ptr_ff, ring_ptr_in;
   logic [CNT_W-1:0] issue_idx_ff, issue_idx_in;
   logic [CNT_W-1:0] chk_idx_ff, chk_idx_in;
   logic        chk_valid_ff, chk_valid_in;
   logic [6:0]  count_ff, count_in;
   alt_cmd_type cur_ff, cur_in;
   alt_res_type hold_ff, hold_in;
   logic        hold_valid_ff, hold_valid_in;
   logic [63:0] tick_ff, tick_in;
   logic [63:0] alloc_cnt_ff, alloc_cnt_in;
   logic [63:0] free_cnt_ff, free_cnt_in;
   logic [63:0] alloc_sum_ff, alloc_sum_in;
   logic [63:0] free_sum_ff, free_sum_in;
   logic        rsp_valid_ff, rsp_valid_in;
   alt_res_type rsp_res_ff;
   logic        rsp_last_ff;
   logic [63:0] rsp_allocs_ff, rsp_frees_ff, rsp_abytes_ff, rsp_fbytes_ff;

   logic        act_we, act_wdata, act_rd;
   logic [IDX_W-1:0] act_waddr, rd_addr;
   logic        rec_we;
   alt_rec_type rec_wdata, rec_rd;
   logic [$bits(alt_rec_type)-1:0] rec_rdata;
   logic        push, push_last, out_free, hit, stall;
   alt_res_type push_res, leak_res;

   // Record fields and active marks live in two RAMs read at the same index.
   alt_ram #(.WIDTH($bits(alt_rec_type)), .DEPTH(TABLE_DEPTH)) u_rec_ram (
      .clock (clock),
      .we    (rec_we),
      .waddr (ring_ptr_ff),
      .wdata (rec_wdata),
      .raddr (rd_addr),
      .rdata (rec_rdata)
   );

   alt_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_act_ram (
      .clock (clock),
      .we    (act_we),
      .waddr (act_waddr),
      .wdata (act_wdata),
      .raddr (rd_addr),
      .rdata (act_rd)
   );

   assign rec_rd          = rec_rdata;
   assign status.enabled  = enabled_ff;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign out_free        = !rsp_valid_ff || rsp_chan.ready;
   assign hit = chk_valid_ff && act_rd &&
                (cur_ff.op == OP_REPORT || rec_rd.address == cur_ff.address);
   assign stall = hit && (cur_ff.op == OP_REPORT) && hold_valid_ff && !out_free;

   // A leak record built from the entry under check.
   always_comb begin
      leak_res         = '0;
      leak_res.kind    = KIND_LEAK;
      leak_res.address = rec_rd.address;
      leak_res.size    = rec_rd.size;
      leak_res.site    = rec_rd.site;
      leak_res.line    = rec_rd.line;
      leak_res.age     = tick_ff - rec_rd.stamp;
   end

   // Command sequencer.
   always_comb begin
      state_in       = state_ff;
      enabled_in     = enabled_ff;
      clr_idx_in     = clr_idx_ff;
      ring_ptr_in    = ring_ptr_ff;
      issue_idx_in   = issue_idx_ff;
      chk_idx_in     = chk_idx_ff;
      chk_valid_in   = chk_valid_ff;
      count_in       = count_ff;
      cur_in         = cur_ff;
      hold_in        = hold_ff;
      hold_valid_in  = hold_valid_ff;
      tick_in        = tick_ff;
      alloc_cnt_in   = alloc_cnt_ff;
      free_cnt_in    = free_cnt_ff;
      alloc_sum_in   = alloc_sum_ff;
      free_sum_in    = free_sum_ff;
      act_we         = 1'b0;
      act_waddr      = clr_idx_ff;
      act_wdata      = 1'b0;
      rec_we         = 1'b0;
      rec_wdata.address = cmd.address;
      rec_wdata.size    = cmd.alloc_size;
      rec_wdata.site    = cmd.site_tag;
      rec_wdata.line    = cmd.line_number;
      rec_wdata.stamp   = tick_ff;
      rd_addr        = '0;
      cmd_pop        = 1'b0;
      push           = 1'b0;
      push_last      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            act_we = 1'b1;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + IDX_ONE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               case (cmd.op)
                  OP_ALLOC: begin
                     rec_we         = 1'b1;
                     act_we         = 1'b1;
                     act_waddr      = ring_ptr_ff;
                     act_wdata      = 1'b1;
                     tick_in        = tick_ff + 64'd1;
                     ring_ptr_in    = (ring_ptr_ff == LAST_IDX) ? '0 : ring_ptr_ff + IDX_ONE;
                     alloc_cnt_in   = alloc_cnt_ff + 64'd1;
                     alloc_sum_in   = alloc_sum_ff + 64'(cmd.alloc_size);
                     hold_in        = plain_result(KIND_ACK, 1'b0);
                     hold_valid_in  = 1'b1;
                     state_in       = ST_FINISH;
                  end
                  OP_FREE, OP_REPORT: begin
                     issue_idx_in  = '0;
                     chk_valid_in  = 1'b0;
                     count_in      = 7'd0;
                     hold_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  OP_EMPTY: begin
                     hold_in       = plain_result(KIND_EMPTY, 1'b0);
                     hold_valid_in = 1'b1;
                     state_in      = ST_FINISH;
                  end
                  default: begin
                     hold_in       = plain_result(KIND_ACK, 1'b0);
                     hold_valid_in = 1'b1;
                     state_in      = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (stall) begin
               // Keep the entry under check on the read port until the output frees.
               rd_addr = chk_idx_ff[IDX_W-1:0];
            end else begin
               rd_addr      = (issue_idx_ff < DEPTH_C) ? issue_idx_ff[IDX_W-1:0] : '0;
               chk_valid_in = (issue_idx_ff < DEPTH_C);
               chk_idx_in   = issue_idx_ff;
               if (issue_idx_ff < DEPTH_C) begin
                  issue_idx_in = issue_idx_ff + CNT_ONE;
               end
               if (hit && cur_ff.op == OP_FREE) begin
                  act_we        = 1'b1;
                  act_waddr     = chk_idx_ff[IDX_W-1:0];
                  act_wdata     = 1'b0;
                  free_sum_in   = free_sum_ff + 64'(rec_rd.size);
                  free_cnt_in   = free_cnt_ff + 64'd1;
                  hold_in       = plain_result(KIND_ACK, 1'b1);
                  hold_valid_in = 1'b1;
                  state_in      = ST_FINISH;
               end else if (hit) begin
                  // An earlier record goes out now that a later one exists.
                  push          = hold_valid_ff;
                  push_last     = 1'b0;
                  hold_in       = leak_res;
                  hold_valid_in = 1'b1;
                  tick_in       = tick_ff + 64'd1;
                  count_in      = count_ff + 7'd1;
                  if (count_ff + 7'd1 == cur_ff.limit) begin
                     state_in = ST_FINISH;
                  end
               end else if (!chk_valid_ff && issue_idx_ff == DEPTH_C) begin
                  state_in = ST_FINISH;
                  if (cur_ff.op == OP_FREE) begin
                     free_cnt_in   = free_cnt_ff + 64'd1;
                     hold_in       = plain_result(KIND_ACK, 1'b0);
                     hold_valid_in = 1'b1;
                  end else if (!hold_valid_ff) begin
                     hold_in       = plain_result(KIND_EMPTY, 1'b0);
                     hold_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Enabling tracking drops every active mark and rewinds the ring.
      if (csr_write_enable) begin
         enabled_in = csr_write_data;
         if (csr_write_data) begin
            state_in    = ST_CLEAR;
            clr_idx_in  = '0;
            ring_ptr_in = '0;
         end
      end
   end

   // Output register.
   always_comb begin
      push_res = hold_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         enabled_ff     <= 1'b0;
         clr_idx_ff     <= '0;
         ring_ptr_ff    <= '0;
         issue_idx_ff   <= '0;
         chk_idx_ff     <= '0;
         chk_valid_ff   <= 1'b0;
         count_ff       <= 7'd0;
         hold_valid_ff  <= 1'b0;
         tick_ff        <= 64'd0;
         alloc_cnt_ff   <= 64'd0;
         free_cnt_ff    <= 64'd0;
         alloc_sum_ff   <= 64'd0;
         free_sum_ff    <= 64'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         enabled_ff     <= enabled_in;
         clr_idx_ff     <= clr_idx_in;
         ring_ptr_ff    <= ring_ptr_in;
         issue_idx_ff   <= issue_idx_in;
         chk_idx_ff     <= chk_idx_in;
         chk_valid_ff   <= chk_valid_in;
         count_ff       <= count_in;
         hold_valid_ff  <= hold_valid_in;
         tick_ff        <= tick_in;
         alloc_cnt_ff   <= alloc_cnt_in;
         free_cnt_ff    <= free_cnt_in;
         alloc_sum_ff   <= alloc_sum_in;
         free_sum_ff    <= free_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers; counters are sampled after the action has updated them.
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      hold_ff <= hold_in;
      if (push) begin
         rsp_res_ff    <= push_res;
         rsp_last_ff   <= push_last;
         rsp_allocs_ff <= alloc_cnt_ff;
         rsp_frees_ff  <= free_cnt_ff;
         rsp_abytes_ff <= alloc_sum_ff;
         rsp_fbytes_ff <= free_sum_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.result_kind     = rsp_res_ff.kind;
   assign rsp_chan.leak_address    = rsp_res_ff.address;
   assign rsp_chan.leak_size       = rsp_res_ff.size;
   assign rsp_chan.leak_site       = rsp_res_ff.site;
   assign rsp_chan.leak_line       = rsp_res_ff.line;
   assign rsp_chan.leak_age        = rsp_res_ff.age;
   assign rsp_chan.free_matched    = rsp_res_ff.matched;
   assign rsp_chan.last            = rsp_last_ff;
   assign rsp_chan.alloc_count     = rsp_allocs_ff;
   assign rsp_chan.free_count      = rsp_frees_ff;
   assign rsp_chan.bytes_allocated = rsp_abytes_ff;
   assign rsp_chan.bytes_freed     = rsp_fbytes_ff;

   `ALT_ASSERT(a_finish_has_result, clock, reset, (state_ff == ST_FINISH) |-> hold_valid_ff)
   `ALT_ASSERT(a_report_within_limit, clock, reset,
               (state_ff == ST_SCAN && cur_ff.op == OP_REPORT) |-> (count_ff < cur_ff.limit))
   `ALT_ASSERT(a_check_in_range, clock, reset, chk_valid_ff |-> (chk_idx_ff < DEPTH_C))
endmodule

@@ rtl/allocation_leak_tracker.sv @@
// Allocation leak tracker: a ring table of allocation records with free matching and
// leak reports. An allocation, or any request while tracking is off or with an unknown
// action, gets its result without a table scan. A free or a report reads the table one
// entry per cycle through the record RAM's single read port; a report holds its scan
// while a found record waits on the output. After reset, and after every write of 1 to
// the enable register, a clearing pass over every table entry resets the active marks;
// requests are not accepted during it. A two-entry command queue lets new requests be
// taken while an earlier one is still being worked on.
module allocation_leak_tracker import alt_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_enable,
   input  logic      csr_write_data,
   alt_req_if.sink   req_chan,
   alt_rsp_if.source rsp_chan
);
   logic           cmd_valid;
   logic           cmd_pop;
   alt_cmd_type    cmd;
   alt_status_type status;

   // Request intake and classification.
   alt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .status    (status),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Table work and result delivery.
   alt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .status           (status),
      .rsp_chan         (rsp_chan)
   );
endmodule

@@ dv/alt_checker.sv @@
// Transaction monitor, leak tracker predictor and response comparison.
`timescale 1ns / 1ps
module alt_checker import alt_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic csr_write_data,
   alt_req_if   req_chan,
   alt_rsp_if   rsp_chan,
   output int   failures,
   output int   pending
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [31:0] size;
      logic [31:0] site;
      logic [19:0] line;
      logic [63:0] age;
      logic        matched;
      logic        last;
      logic [63:0] allocs;
      logic [63:0] frees;
      logic [63:0] bytes_in;
      logic [63:0] bytes_out;
   } tracker_result_type;

   // Predicted tracker state.
   logic [31:0] rec_address [TABLE_DEPTH];
   logic [31:0] rec_size [TABLE_DEPTH];
   logic [31:0] rec_site [TABLE_DEPTH];
   logic [19:0] rec_line [TABLE_DEPTH];
   logic [63:0] rec_stamp [TABLE_DEPTH];
   bit          rec_active [TABLE_DEPTH];
   int unsigned ring_ptr;
   logic [63:0] tick, alloc_total, free_total, alloc_sum, free_sum;
   bit          tracking_on;

   tracker_result_type expected_results [$];

   assign pending = expected_results.size();

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      failures++;
   endtask

   function automatic tracker_result_type counters_only(input logic [1:0] kind,
                                                        input logic hit);
      tracker_result_type r;
      r = '0;
      r.kind = kind;
      r.matched = hit;
      r.allocs = alloc_total;
      r.frees = free_total;
      r.bytes_in = alloc_sum;
      r.bytes_out = free_sum;
      return r;
   endfunction

   // Work out the results of one accepted request and queue them.
   task automatic predict_tracker(input logic [1:0] action, input logic [31:0] addr,
                                  input logic [31:0] size, input logic [31:0] site,
                                  input logic [19:0] line, input logic [6:0] max_rep);
      tracker_result_type r;
      tracker_result_type found [$];
      int unsigned limit;
      bit hit;
      limit = (max_rep > REPORT_CAP) ? REPORT_CAP : max_rep;
      hit = 0;
      if (!tracking_on || !(action inside {ACT_ALLOC, ACT_FREE, ACT_REPORT})) begin
         r = counters_only(action == ACT_REPORT ? KIND_EMPTY : KIND_ACK, 1'b0);
         r.last = 1'b1;
         expected_results.push_back(r);
      end else if (action == ACT_ALLOC) begin
         rec_address[ring_ptr] = addr;
         rec_size[ring_ptr] = size;
         rec_site[ring_ptr] = site;
         rec_line[ring_ptr] = line;
         rec_stamp[ring_ptr] = tick;
         rec_active[ring_ptr] = 1'b1;
         tick++;
         ring_ptr = (ring_ptr + 1) % TABLE_DEPTH;
         alloc_total++;
         alloc_sum += 64'(size);
         r = counters_only(KIND_ACK, 1'b0);
         r.last = 1'b1;
         expected_results.push_back(r);
      end else if (action == ACT_FREE) begin
         // The first active record with this address is the one released.
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (rec_active[i] && rec_address[i] == addr) begin
               free_sum += 64'(rec_size[i]);
               rec_active[i] = 1'b0;
               hit = 1'b1;
               break;
            end
         end
         free_total++;
         r = counters_only(KIND_ACK, hit);
         r.last = 1'b1;
         expected_results.push_back(r);
      end else begin
         // Report: active records in index order, each one advancing the tick.
         for (int i = 0; i < TABLE_DEPTH && found.size() < limit; i++) begin
            if (rec_active[i]) begin
               r = counters_only(KIND_LEAK, 1'b0);
               r.address = rec_address[i];
               r.size = rec_size[i];
               r.site = rec_site[i];
               r.line = rec_line[i];
               r.age = tick - rec_stamp[i];
               tick++;
               found.push_back(r);
            end
         end
         if (found.size() == 0)
            found.push_back(counters_only(KIND_EMPTY, 1'b0));
         found[found.size() - 1].last = 1'b1;
         foreach (found[k])
            expected_results.push_back(found[k]);
      end
   endtask

   // Compare one accepted response with the oldest expectation.
   task automatic compare_response();
      tracker_result_type e;
      if (expected_results.size() == 0) begin
         report_mismatch("response transaction with nothing expected");
         return;
      end
      e = expected_results.pop_front();
      if (rsp_chan.result_kind !== e.kind)
         report_mismatch($sformatf("result_kind %0d, expected %0d", rsp_chan.result_kind, e.kind));
      if (rsp_chan.leak_address !== e.address)
         report_mismatch($sformatf("leak_address %h, expected %h", rsp_chan.leak_address,
                                   e.address));
      if (rsp_chan.leak_size !== e.size)
         report_mismatch($sformatf("leak_size %h, expected %h", rsp_chan.leak_size, e.size));
      if (rsp_chan.leak_site !== e.site)
         report_mismatch($sformatf("leak_site %h, expected %h", rsp_chan.leak_site, e.site));
      if (rsp_chan.leak_line !== e.line)
         report_mismatch($sformatf("leak_line %h, expected %h", rsp_chan.leak_line, e.line));
      if (rsp_chan.leak_age !== e.age)
         report_mismatch($sformatf("leak_age %0d, expected %0d", rsp_chan.leak_age, e.age));
      if (rsp_chan.free_matched !== e.matched)
         report_mismatch($sformatf("free_matched %b, expected %b", rsp_chan.free_matched,
                                   e.matched));
      if (rsp_chan.last !== e.last)
         report_mismatch($sformatf("last %b, expected %b", rsp_chan.last, e.last));
      if (rsp_chan.alloc_count !== e.allocs)
         report_mismatch($sformatf("alloc_count %0d, expected %0d", rsp_chan.alloc_count,
                                   e.allocs));
      if (rsp_chan.free_count !== e.frees)
         report_mismatch($sformatf("free_count %0d, expected %0d", rsp_chan.free_count,
                                   e.frees));
      if (rsp_chan.bytes_allocated !== e.bytes_in)
         report_mismatch($sformatf("bytes_allocated %0d, expected %0d",
                                   rsp_chan.bytes_allocated, e.bytes_in));
      if (rsp_chan.bytes_freed !== e.bytes_out)
         report_mismatch($sformatf("bytes_freed %0d, expected %0d", rsp_chan.bytes_freed,
                                   e.bytes_out));
   endtask

   initial failures = 0;

   // Watch the register port and both channels on every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         foreach (rec_active[i]) rec_active[i] = 1'b0;
         ring_ptr = 0;
         tick = '0;
         alloc_total = '0;
         free_total = '0;
         alloc_sum = '0;
         free_sum = '0;
         tracking_on = 1'b0;
         expected_results.delete();
      end else begin
         if (csr_write_enable === 1'b1) begin
            tracking_on = csr_write_data;
            if (csr_write_data) begin
               foreach (rec_active[i]) rec_active[i] = 1'b0;
               ring_ptr = 0;
            end
         end
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            compare_response();
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            predict_tracker(req_chan.action, req_chan.address, req_chan.alloc_size,
                            req_chan.site_tag, req_chan.line_number, req_chan.report_limit);
      end
   end

endmodule

@@ dv/tb.sv @@
// Top of the leak tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
   import alt_pkg::*;

   localparam int TABLE_DEPTH = 1024;
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 3000000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;
   int   failures;
   int   pending;
   int   cycles;
   bit   idling_on;
   int   stall_left;
   logic [31:0] address_pool [16];

   alt_req_if req_chan ();
   alt_rsp_if rsp_chan ();

   allocation_leak_tracker #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source)
   );

   alt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .failures         (failures),
      .pending          (pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Response side stalls in random bursts while idling is on.
   initial stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Present one request transaction and hold it until it is accepted.
   task automatic send_request(input logic [1:0] action, input logic [31:0] addr,
                               input logic [31:0] size, input logic [31:0] site,
                               input logic [19:0] line, input logic [6:0] max_rep);
      bit taken;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= action;
      req_chan.address <= addr;
      req_chan.alloc_size <= size;
      req_chan.site_tag <= site;
      req_chan.line_number <= line;
      req_chan.report_limit <= max_rep;
      do begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Drain outstanding results, then write the enable register.
   task automatic write_enable(input logic value);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One random request, with addresses mostly drawn from a small pool so that frees often hit allocations.
   task automatic random_request();
      logic [31:0] addr;
      int unsigned pick;
      addr = ($urandom_range(0, 7) == 0) ? $urandom() : address_pool[$urandom_range(0, 15)];
      pick = $urandom_range(0, 99);
      if (pick < 45)
         send_request(ACT_ALLOC, addr, $urandom(), $urandom(), 20'($urandom()), 7'($urandom()));
      else if (pick < 80)
         send_request(ACT_FREE, addr, $urandom(), $urandom(), 20'($urandom()), 7'($urandom()));
      else if (pick < 96)
         send_request(ACT_REPORT, $urandom(), $urandom(), $urandom(), 20'($urandom()),
                      ($urandom_range(0, 3) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 6)));
      else
         send_request(ACT_UNKNOWN, $urandom(), $urandom(), $urandom(), 20'($urandom()),
                      7'($urandom()));
   endtask

   initial begin
      foreach (address_pool[i]) address_pool[i] = $urandom();
      address_pool[0] = 32'h0000_0000;
      address_pool[1] = 32'hFFFF_FFFF;
      idling_on = 1'b1;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.action = ACT_ALLOC;
      req_chan.address = '0;
      req_chan.alloc_size = '0;
      req_chan.site_tag = '0;
      req_chan.line_number = '0;
      req_chan.report_limit = '0;
      rsp_chan.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Tracking off after reset: allocations and frees are only acknowledged, a report comes back empty.
      send_request(ACT_ALLOC, 32'h1234_5678, 32'd99, 32'd7, 20'd3, 7'd5);
      send_request(ACT_FREE, 32'h1234_5678, 32'd0, 32'd0, 20'd0, 7'd0);
      send_request(ACT_REPORT, 32'd0, 32'd0, 32'd0, 20'd0, 7'd64);

      // Directed: field extremes, matches and misses, report limits.
      write_enable(1'b1);
      send_request(ACT_REPORT, 32'd0, 32'd0, 32'd0, 20'd0, 7'd10);
      send_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 7'h7F);
      send_request(ACT_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 20'h00000, 7'h00);
      send_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'h8000_0001, 32'h5A5A_A5A5, 20'h5A5A5, 7'd1);
      send_request(ACT_REPORT, 32'd0, 32'd0, 32'd0, 20'd0, 7'd0);
      send_request(ACT_REPORT, 32'd0, 32'd0, 32'd0, 20'd0, 7'd2);
      send_request(ACT_REPORT, 32'd0, 32'd0, 32'd0, 20'd0, 7'h7F);
      send_request(ACT_FREE, 32'hFFFF_FFFF, 32'd0, 32'd0, 20'd0, 7'd0);
      send_request(ACT_FREE, 32'hDEAD_BEEF, 32'd0, 32'd0, 20'd0, 7'd0);
      send_request(ACT_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 7'h7F);
      send_request(ACT_REPORT, 32'd0, 32'd0, 32'd0, 20'd0, 7'd65);
      send_request(ACT_FREE, 32'hFFFF_FFFF, 32'd0, 32'd0, 20'd0, 7'd0);
      send_request(ACT_FREE, 32'h0000_0000, 32'd0, 32'd0, 20'd0, 7'd0);
      send_request(ACT_REPORT, 32'd0, 32'd0, 32'd0, 20'd0, 7'd64);

      // Writing 1 again while on clears the table; then a back-to-back burst of
      // allocations with repeated addresses.
      write_enable(1'b1);
      idling_on = 1'b0;
      for (int i = 0; i < 20; i++)
         send_request(ACT_ALLOC, address_pool[i % 16], $urandom(), $urandom(),
                      20'($urandom()), 7'd0);
      idling_on = 1'b1;
      send_request(ACT_FREE, address_pool[3], 32'd0, 32'd0, 20'd0, 7'd0);
      send_request(ACT_REPORT, 32'd0, 32'd0, 32'd0, 20'd0, 7'd64);

      // Random traffic on a fresh table.
      write_enable(1'b1);
      for (int i = 0; i < 60; i++) begin
         random_request();
         if (i == 35) begin
            // Hold the sender until every outstanding result has come back.
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
      end

      // Tracking off keeps the table; turning it on again clears it.
      write_enable(1'b0);
      for (int i = 0; i < 20; i++) random_request();
      write_enable(1'b1);
      for (int i = 0; i < 40; i++) random_request();

      // Last stretch with no idling on either side.
      idling_on = 1'b0;
      for (int i = 0; i < 50; i++) random_request();
      req_chan.valid <= 1'b0;
      @(posedge clock);

      while (pending != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 20) @(posedge clock);
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
